FILE: rtl/core/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types and constants of the transport stream PID demultiplexer.
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'h47;
  localparam logic [7:0] PKT_LAST    = 8'd187;
  localparam logic [8:0] PKT_LEN     = 9'd188;
  localparam logic [4:0] PID_HI_MASK = 5'h1F;
  localparam logic [12:0] PAT_MIN    = 13'd12;
  localparam logic [12:0] PMT_MIN    = 13'd16;
  localparam logic [7:0] ADAPT_ALL   = 8'd183;

  typedef enum logic [2:0] {
    KIND_VIDEO     = 3'd0,
    KIND_AUDIO     = 3'd1,
    KIND_SYNC_LOSS = 3'd2,
    KIND_BAD_PKT   = 3'd3,
    KIND_BAD_PSI   = 3'd4,
    KIND_PMT_PID   = 3'd5,
    KIND_VID_PID   = 3'd6,
    KIND_AUD_PID   = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    MODE_SKIP     = 3'd0,
    MODE_AWAIT    = 3'd1,
    MODE_PAT      = 3'd2,
    MODE_PMT_HDR  = 3'd3,
    MODE_PMT_LOOP = 3'd4,
    MODE_VIDEO    = 3'd5,
    MODE_AUDIO    = 3'd6
  } mode_t;

  typedef enum logic [0:0] {
    REG_VIDEO_TYPE = 1'b0,
    REG_AUDIO_TYPE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic        pay_start;
    logic        packet_last;
    logic [12:0] learned_pid;
  } result_t;

endpackage

FILE: rtl/core/ts_packet_pid_demux.sv
// ----------------------------------------------------------------------------
// ts_packet_pid_demux
// MPEG transport stream PID demultiplexer: learns the PMT, video and audio
// PIDs from the PAT and PMT and emits tagged elementary stream bytes.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Request payload
// in_       input      in_valid/in_ready   ts_byte
// out_      output     out_valid/out_ready kind, data_byte, pay_start,
//                                          packet_last, learned_pid
// cfg_      input      cfg_wr_en           cfg_index, cfg_wdata
//
// One byte is parsed per cycle while the queue has room; the parser state
// updates in the same cycle the request is accepted, so the sustained rate
// is one byte per clock while the output keeps up. Each result is held in
// a two-entry queue, registered, before it appears on the output.
// Reset is synchronous and active low and needs no clearing pass.
// A stalled output only stops input once both queue entries are full.
// ----------------------------------------------------------------------------
module ts_packet_pid_demux import tpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ts_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic        out_pay_start,
  output logic        out_packet_last,
  output logic [12:0] out_learned_pid,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0] video_type_r;
  logic [7:0] audio_type_r;
  logic       in_fire;
  logic       res_valid;
  result_t    res;
  result_t    head;
  logic [1:0] q_count;

  // Stream type registers; the user must write them only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_type_r <= 8'd27;
      audio_type_r <= 8'd15;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_VIDEO_TYPE) video_type_r <= cfg_wdata;
      else audio_type_r <= cfg_wdata;
    end
  end

  assign in_fire = in_valid && in_ready;

  // Front part: the parser classifies each byte as it is accepted.
  tpd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (in_fire),
    .ts_byte    (in_ts_byte),
    .video_type (video_type_r),
    .audio_type (audio_type_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Back part: the queue holds results until the consumer takes them.
  tpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire && res_valid),
    .push_data  (res),
    .has_room   (in_ready),
    .pop        (out_valid && out_ready),
    .head_valid (out_valid),
    .head       (head),
    .count      (q_count)
  );

  assign out_kind        = head.kind;
  assign out_data_byte   = head.data_byte;
  assign out_pay_start   = head.pay_start;
  assign out_packet_last = head.packet_last;
  assign out_learned_pid = head.learned_pid;

  // The queue never overfills.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count != 2'd3) else $error("result queue overflow");

  // Ready drops only when the queue is full.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_count == 2'd2) else $error("input stalled with room");

  // A learned PID is only reported with a PID kind.
  a_pid_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_learned_pid != 13'd0 |->
      (out_kind == KIND_PMT_PID || out_kind == KIND_VID_PID ||
       out_kind == KIND_AUD_PID)) else $error("PID on wrong kind");

  // Start and last flags only accompany payload bytes.
  a_flag_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pay_start || out_packet_last) |->
      (out_kind == KIND_VIDEO || out_kind == KIND_AUDIO))
    else $error("payload flag on wrong kind");

endmodule

FILE: rtl/core/tpd_parser.sv
// ----------------------------------------------------------------------------
// tpd_parser
// Front part: byte-wise packet parser, PAT/PMT decoder and PID filter.
// ----------------------------------------------------------------------------
module tpd_parser import tpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_en,
  input  logic [7:0]  ts_byte,
  input  logic [7:0]  video_type,
  input  logic [7:0]  audio_type,
  output logic        res_valid,
  output result_t     res
);

  logic        in_packet_r, in_packet_nxt;
  logic [7:0]  byte_index_r, byte_index_nxt;
  logic [12:0] packet_pid_r, packet_pid_nxt;
  logic        unit_start_r, unit_start_nxt;
  logic [1:0]  adapt_r, adapt_nxt;
  logic [7:0]  pay_off_r, pay_off_nxt;
  mode_t       mode_r, mode_nxt;
  logic [11:0] sec_len_r, sec_len_nxt;
  logic [11:0] pil_r, pil_nxt;
  logic [11:0] ent_off_r, ent_off_nxt;
  logic [7:0]  ent_type_r, ent_type_nxt;
  logic [12:0] ent_pid_r, ent_pid_nxt;
  logic        pmt_known_r, pmt_known_nxt;
  logic [12:0] pmt_pid_r, pmt_pid_nxt;
  logic        video_known_r, video_known_nxt;
  logic [12:0] vid_pid_r, vid_pid_nxt;
  logic        audio_known_r, audio_known_nxt;
  logic [12:0] aud_pid_r, aud_pid_nxt;

  always_comb begin
    logic [7:0]  b;
    logic [7:0]  idx;
    logic [7:0]  so;
    logic [12:0] slen;
    logic [12:0] pe;
    logic [12:0] d;
    logic [12:0] eil;
    logic [12:0] neo;
    logic [12:0] pil_w;
    logic [8:0]  rem;
    logic        pat;
    logic        psi_go;
    b = ts_byte;
    idx = byte_index_r;
    so = '0;
    slen = '0;
    pe = '0;
    d = '0;
    eil = '0;
    neo = '0;
    pil_w = '0;
    rem = '0;
    pat = 1'b0;
    psi_go = 1'b0;
    in_packet_nxt = in_packet_r;
    byte_index_nxt = byte_index_r;
    packet_pid_nxt = packet_pid_r;
    unit_start_nxt = unit_start_r;
    adapt_nxt = adapt_r;
    pay_off_nxt = pay_off_r;
    mode_nxt = mode_r;
    sec_len_nxt = sec_len_r;
    pil_nxt = pil_r;
    ent_off_nxt = ent_off_r;
    ent_type_nxt = ent_type_r;
    ent_pid_nxt = ent_pid_r;
    pmt_known_nxt = pmt_known_r;
    pmt_pid_nxt = pmt_pid_r;
    video_known_nxt = video_known_r;
    vid_pid_nxt = vid_pid_r;
    audio_known_nxt = audio_known_r;
    aud_pid_nxt = aud_pid_r;
    res_valid = 1'b0;
    res = '{kind: KIND_VIDEO, data_byte: '0, pay_start: 1'b0, packet_last: 1'b0,
            learned_pid: '0};

    if (!in_packet_r) begin
      if (b != SYNC_BYTE) begin
        res_valid = 1'b1;
        res.kind = KIND_SYNC_LOSS;
      end else begin
        in_packet_nxt = 1'b1;
        byte_index_nxt = 8'd1;
        mode_nxt = MODE_AWAIT;
        pay_off_nxt = '0;
        adapt_nxt = '0;
      end
    end else begin
      if (idx >= PKT_LAST) begin
        in_packet_nxt = 1'b0;
        byte_index_nxt = '0;
      end else begin
        byte_index_nxt = idx + 8'd1;
      end
      if (idx == 8'd1) begin
        packet_pid_nxt = {b[4:0] & PID_HI_MASK, 8'h00};
        unit_start_nxt = b[6];
      end else if (idx == 8'd2) begin
        packet_pid_nxt = packet_pid_r | {5'd0, b};
      end else if (idx == 8'd3) begin
        adapt_nxt = b[5:4];
        if (b[5:4] == 2'd0) begin
          mode_nxt = MODE_SKIP;
          res_valid = 1'b1;
          res.kind = KIND_BAD_PKT;
        end else if (b[5:4] == 2'd2) begin
          mode_nxt = MODE_SKIP;
        end else if (b[5:4] == 2'd1) begin
          pay_off_nxt = 8'd4;
        end
      end else if (idx == 8'd4 && adapt_r == 2'd3 && mode_r == MODE_AWAIT) begin
        if (b > ADAPT_ALL) begin
          mode_nxt = MODE_SKIP;
          res_valid = 1'b1;
          res.kind = KIND_BAD_PKT;
        end else if (b == ADAPT_ALL) begin
          mode_nxt = MODE_SKIP;
        end else begin
          pay_off_nxt = b + 8'd5;
        end
      end else begin
        // Payload start: decide what this packet carries.
        if (mode_r == MODE_AWAIT && pay_off_r != 8'd0 && idx == pay_off_r) begin
          if (packet_pid_r == 13'd0 || (pmt_known_r && packet_pid_r == pmt_pid_r)) begin
            rem = 9'(PKT_LEN - 9'd1 - {1'b0, idx});
            if (!unit_start_r) begin
              mode_nxt = MODE_SKIP;
            end else begin
              mode_nxt = (packet_pid_r == 13'd0) ? MODE_PAT : MODE_PMT_HDR;
              if ({1'b0, b} > rem ||
                  13'({4'd0, rem} - {5'd0, b}) <
                  ((packet_pid_r == 13'd0) ? PAT_MIN : PMT_MIN)) begin
                mode_nxt = MODE_SKIP;
                res_valid = 1'b1;
                res.kind = KIND_BAD_PSI;
              end else begin
                pay_off_nxt = idx + 8'd1 + b;
              end
            end
          end else if (video_known_r && packet_pid_r == vid_pid_r) begin
            mode_nxt = MODE_VIDEO;
          end else if (audio_known_r && packet_pid_r == aud_pid_r) begin
            mode_nxt = MODE_AUDIO;
          end else begin
            mode_nxt = MODE_SKIP;
          end
          if (mode_nxt == MODE_VIDEO || mode_nxt == MODE_AUDIO) begin
            res_valid = 1'b1;
            res.kind = (mode_nxt == MODE_VIDEO) ? KIND_VIDEO : KIND_AUDIO;
            res.data_byte = b;
            res.pay_start = unit_start_r;
            res.packet_last = (idx == PKT_LAST);
          end
        end else if (mode_r == MODE_VIDEO || mode_r == MODE_AUDIO) begin
          res_valid = 1'b1;
          res.kind = (mode_r == MODE_VIDEO) ? KIND_VIDEO : KIND_AUDIO;
          res.data_byte = b;
          res.pay_start = unit_start_r && (idx == pay_off_r);
          res.packet_last = (idx == PKT_LAST);
        end else if ((mode_r == MODE_PAT || mode_r == MODE_PMT_HDR ||
                      mode_r == MODE_PMT_LOOP) && idx >= pay_off_r) begin
          psi_go = 1'b1;
        end
      end

      if (psi_go) begin
        so = idx - pay_off_r;
        pat = (mode_r == MODE_PAT);
        slen = {1'b0, sec_len_r} + 13'd3;
        pe = slen - 13'd4;
        if (mode_r == MODE_PMT_LOOP) begin
          if ({4'd0, so} >= ent_off_r) begin
            d = {5'd0, so} - {1'b0, ent_off_r};
            if (d == 13'd0) begin
              ent_type_nxt = b;
            end else if (d == 13'd1) begin
              ent_pid_nxt = {b[4:0] & PID_HI_MASK, 8'h00};
            end else if (d == 13'd2) begin
              ent_pid_nxt = ent_pid_r | {5'd0, b};
            end else if (d == 13'd3) begin
              pil_nxt = {b[3:0], 8'h00};
            end else begin
              eil = {1'b0, pil_r | {4'd0, b}};
              if (eil > pe - {1'b0, ent_off_r} - 13'd5) begin
                mode_nxt = MODE_SKIP;
                res_valid = 1'b1;
                res.kind = KIND_BAD_PSI;
              end else begin
                neo = {1'b0, ent_off_r} + 13'd5 + eil;
                ent_off_nxt = neo[11:0];
                if (pe - {1'b0, neo[11:0]} < 13'd5) mode_nxt = MODE_SKIP;
                if (ent_type_r == video_type) begin
                  if (!video_known_r || vid_pid_r != ent_pid_r) begin
                    video_known_nxt = 1'b1;
                    vid_pid_nxt = ent_pid_r;
                    res_valid = 1'b1;
                    res.kind = KIND_VID_PID;
                    res.learned_pid = ent_pid_r;
                  end
                end else if (ent_type_r == audio_type) begin
                  if (!audio_known_r || aud_pid_r != ent_pid_r) begin
                    audio_known_nxt = 1'b1;
                    aud_pid_nxt = ent_pid_r;
                    res_valid = 1'b1;
                    res.kind = KIND_AUD_PID;
                    res.learned_pid = ent_pid_r;
                  end
                end
              end
            end
          end
        end else if (so == 8'd0) begin
          if (b != (pat ? 8'd0 : 8'd2)) begin
            mode_nxt = MODE_SKIP;
            res_valid = 1'b1;
            res.kind = KIND_BAD_PSI;
          end
        end else if (so == 8'd1) begin
          sec_len_nxt = {b[3:0], 8'h00};
        end else if (so == 8'd2) begin
          sec_len_nxt = sec_len_r | {4'd0, b};
          slen = {1'b0, sec_len_r | {4'd0, b}} + 13'd3;
          if (slen < (pat ? PAT_MIN : PMT_MIN) ||
              slen > 13'({4'd0, PKT_LEN} - {5'd0, pay_off_r})) begin
            mode_nxt = MODE_SKIP;
            res_valid = 1'b1;
            res.kind = KIND_BAD_PSI;
          end
        end else if (so == 8'd10) begin
          if (pat) ent_pid_nxt = {b[4:0] & PID_HI_MASK, 8'h00};
          else pil_nxt = {b[3:0], 8'h00};
        end else if (so == 8'd11) begin
          if (pat) begin
            mode_nxt = MODE_SKIP;
            if (!pmt_known_r || pmt_pid_r != (ent_pid_r | {5'd0, b})) begin
              pmt_known_nxt = 1'b1;
              pmt_pid_nxt = ent_pid_r | {5'd0, b};
              res_valid = 1'b1;
              res.kind = KIND_PMT_PID;
              res.learned_pid = ent_pid_r | {5'd0, b};
            end
            ent_pid_nxt = ent_pid_r | {5'd0, b};
          end else begin
            pil_w = {1'b0, pil_r | {4'd0, b}};
            pil_nxt = pil_w[11:0];
            if (pil_w > slen - PMT_MIN) begin
              mode_nxt = MODE_SKIP;
              res_valid = 1'b1;
              res.kind = KIND_BAD_PSI;
            end else begin
              neo = 13'd12 + pil_w;
              ent_off_nxt = neo[11:0];
              mode_nxt = (pe - {1'b0, neo[11:0]} < 13'd5) ? MODE_SKIP : MODE_PMT_LOOP;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r <= 1'b0;
      byte_index_r <= '0;
      packet_pid_r <= '0;
      unit_start_r <= 1'b0;
      adapt_r <= '0;
      pay_off_r <= '0;
      mode_r <= MODE_SKIP;
      sec_len_r <= '0;
      pil_r <= '0;
      ent_off_r <= '0;
      ent_type_r <= '0;
      ent_pid_r <= '0;
      pmt_known_r <= 1'b0;
      pmt_pid_r <= '0;
      video_known_r <= 1'b0;
      vid_pid_r <= '0;
      audio_known_r <= 1'b0;
      aud_pid_r <= '0;
    end else if (byte_en) begin
      in_packet_r <= in_packet_nxt;
      byte_index_r <= byte_index_nxt;
      packet_pid_r <= packet_pid_nxt;
      unit_start_r <= unit_start_nxt;
      adapt_r <= adapt_nxt;
      pay_off_r <= pay_off_nxt;
      mode_r <= mode_nxt;
      sec_len_r <= sec_len_nxt;
      pil_r <= pil_nxt;
      ent_off_r <= ent_off_nxt;
      ent_type_r <= ent_type_nxt;
      ent_pid_r <= ent_pid_nxt;
      pmt_known_r <= pmt_known_nxt;
      pmt_pid_r <= pmt_pid_nxt;
      video_known_r <= video_known_nxt;
      vid_pid_r <= vid_pid_nxt;
      audio_known_r <= audio_known_nxt;
      aud_pid_r <= aud_pid_nxt;
    end
  end

endmodule

FILE: rtl/core/tpd_queue.sv
// ----------------------------------------------------------------------------
// tpd_queue
// Back part: two-entry result queue that drives the output channel.
// ----------------------------------------------------------------------------
module tpd_queue import tpd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    has_room,
  input  logic    pop,
  output logic    head_valid,
  output result_t head,
  output logic [1:0] count
);

  result_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign has_room   = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];
  assign count      = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: verif/ts_packet_pid_demux_tb.sv
// ----------------------------------------------------------------------------
// ts_packet_pid_demux_tb
// Self-checking bench for the transport stream PID demultiplexer. It builds
// PAT, PMT and elementary stream packets with random content, noise and
// broken packets, and checks every tagged result against a bytewise model.
// ----------------------------------------------------------------------------
module ts_packet_pid_demux_tb import tpd_pkg::*; ();

  // Model of the demultiplexer plus the queue of results it still owes.
  class pid_demux_predictor;
    bit [7:0]  video_type = 8'd27;
    bit [7:0]  audio_type = 8'd15;
    bit        in_pkt;
    bit [7:0]  byte_idx;
    bit [12:0] pkt_pid;
    bit        pusi;
    bit [1:0]  afc;
    bit [7:0]  pay_off;
    mode_t     mode = MODE_SKIP;
    bit [11:0] sec_len;
    bit [11:0] info_len;
    bit [11:0] entry_off;
    bit [7:0]  entry_ty;
    bit [12:0] entry_pid;
    bit        pmt_known, video_known, audio_known;
    bit [12:0] pmt_pid, vid_pid, aud_pid;
    result_t   expected_results[$];
    int        fails;

    function void set_reg(reg_idx_t idx, bit [7:0] v);
      if (idx == REG_VIDEO_TYPE) video_type = v;
      else audio_type = v;
    endfunction

    function void push(kind_t k, bit [7:0] d, bit ps, bit last, bit [12:0] pid);
      result_t r;
      r.kind = k;
      r.data_byte = d;
      r.pay_start = ps;
      r.packet_last = last;
      r.learned_pid = pid;
      expected_results.push_back(r);
    endfunction

    function void bad_psi();
      mode = MODE_SKIP;
      push(KIND_BAD_PSI, 8'd0, 1'b0, 1'b0, 13'd0);
    endfunction

    // One section byte of a PAT or PMT at section offset so.
    function void section_byte(int unsigned so, bit [7:0] b);
      bit pat;
      int unsigned sl, pe, d, eil;
      pat = (mode == MODE_PAT);
      sl = int'(sec_len) + 3;
      pe = sl - 4;
      if (mode == MODE_PMT_LOOP) begin
        if (so < entry_off) return;
        d = so - entry_off;
        case (d)
          0: entry_ty = b;
          1: entry_pid = {b[4:0], 8'h00};
          2: entry_pid = entry_pid | b;
          3: info_len = {b[3:0], 8'h00};
          default: begin
            eil = int'(info_len) | b;
            if (eil > pe - entry_off - 5) begin
              bad_psi();
              return;
            end
            entry_off = 12'(entry_off + 5 + eil);
            if (pe - entry_off < 5) mode = MODE_SKIP;
            if (entry_ty == video_type) begin
              if (!video_known || vid_pid != entry_pid) begin
                video_known = 1;
                vid_pid = entry_pid;
                push(KIND_VID_PID, 8'd0, 1'b0, 1'b0, entry_pid);
              end
            end else if (entry_ty == audio_type) begin
              if (!audio_known || aud_pid != entry_pid) begin
                audio_known = 1;
                aud_pid = entry_pid;
                push(KIND_AUD_PID, 8'd0, 1'b0, 1'b0, entry_pid);
              end
            end
          end
        endcase
        return;
      end
      case (so)
        0: if (b != (pat ? 8'd0 : 8'd2)) bad_psi();
        1: sec_len = {b[3:0], 8'h00};
        2: begin
          sec_len = sec_len | b;
          sl = int'(sec_len) + 3;
          if (sl < (pat ? 12 : 16) || sl > 188 - pay_off) bad_psi();
        end
        10: begin
          if (pat) entry_pid = {b[4:0], 8'h00};
          else info_len = {b[3:0], 8'h00};
        end
        11: begin
          if (pat) begin
            entry_pid = entry_pid | b;
            mode = MODE_SKIP;
            if (!pmt_known || pmt_pid != entry_pid) begin
              pmt_known = 1;
              pmt_pid = entry_pid;
              push(KIND_PMT_PID, 8'd0, 1'b0, 1'b0, entry_pid);
            end
          end else begin
            info_len = info_len | b;
            if (info_len > sl - 16) begin
              bad_psi();
              return;
            end
            entry_off = 12'(12 + info_len);
            mode = (pe - entry_off < 5) ? MODE_SKIP : MODE_PMT_LOOP;
          end
        end
        default: ;
      endcase
    endfunction

    function void packet_byte(int unsigned idx, bit [7:0] b);
      int unsigned rem, need;
      if (idx == 1) begin
        pkt_pid = {b[4:0], 8'h00};
        pusi = b[6];
        return;
      end
      if (idx == 2) begin
        pkt_pid = pkt_pid | b;
        return;
      end
      if (idx == 3) begin
        afc = b[5:4];
        if (afc == 2'd0) begin
          mode = MODE_SKIP;
          push(KIND_BAD_PKT, 8'd0, 1'b0, 1'b0, 13'd0);
        end else if (afc == 2'd2) mode = MODE_SKIP;
        else if (afc == 2'd1) pay_off = 8'd4;
        return;
      end
      if (idx == 4 && afc == 2'd3 && mode == MODE_AWAIT) begin
        if (b > 183) begin
          mode = MODE_SKIP;
          push(KIND_BAD_PKT, 8'd0, 1'b0, 1'b0, 13'd0);
        end else if (b == 183) mode = MODE_SKIP;
        else pay_off = 8'd5 + b;
        return;
      end
      if (mode == MODE_AWAIT) begin
        if (pay_off == 0 || idx != pay_off) return;
        if (pkt_pid == 0 || (pmt_known && pkt_pid == pmt_pid)) begin
          rem = 188 - idx - 1;
          need = (pkt_pid == 0) ? 12 : 16;
          if (!pusi) begin
            mode = MODE_SKIP;
            return;
          end
          mode = (pkt_pid == 0) ? MODE_PAT : MODE_PMT_HDR;
          if (b > rem || rem - b < need) begin
            bad_psi();
            return;
          end
          pay_off = 8'(idx + 1 + b);
          return;
        end
        if (video_known && pkt_pid == vid_pid) mode = MODE_VIDEO;
        else if (audio_known && pkt_pid == aud_pid) mode = MODE_AUDIO;
        else begin
          mode = MODE_SKIP;
          return;
        end
      end
      if (mode == MODE_VIDEO || mode == MODE_AUDIO) begin
        push(mode == MODE_VIDEO ? KIND_VIDEO : KIND_AUDIO, b,
             pusi && idx == pay_off, idx == 187, 13'd0);
      end else if (mode == MODE_PAT || mode == MODE_PMT_HDR || mode == MODE_PMT_LOOP) begin
        if (idx >= pay_off) section_byte(idx - pay_off, b);
      end
    endfunction

    function void accept_byte(bit [7:0] b);
      int unsigned idx;
      if (!in_pkt) begin
        if (b != SYNC_BYTE) begin
          push(KIND_SYNC_LOSS, 8'd0, 1'b0, 1'b0, 13'd0);
        end else begin
          in_pkt = 1;
          byte_idx = 8'd1;
          mode = MODE_AWAIT;
          pay_off = 8'd0;
          afc = 2'd0;
        end
        return;
      end
      idx = byte_idx;
      packet_byte(idx, b);
      if (idx >= 187) begin
        in_pkt = 0;
        byte_idx = 8'd0;
      end else byte_idx = 8'(idx + 1);
    endfunction

    function void check_result(logic [2:0] k, logic [7:0] d, logic ps, logic pl,
                               logic [12:0] lp);
      result_t e;
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d data %0h pid %0h", k, d, lp);
        fails++;
        return;
      end
      e = expected_results.pop_front();
      if (e.kind !== k) begin
        $error("kind: expected %0d, actual %0d", e.kind, k);
        fails++;
      end
      if (e.data_byte !== d) begin
        $error("data_byte: expected %0h, actual %0h", e.data_byte, d);
        fails++;
      end
      if (e.pay_start !== ps) begin
        $error("pay_start: expected %0b, actual %0b", e.pay_start, ps);
        fails++;
      end
      if (e.packet_last !== pl) begin
        $error("packet_last: expected %0b, actual %0b", e.packet_last, pl);
        fails++;
      end
      if (e.learned_pid !== lp) begin
        $error("learned_pid: expected %0h, actual %0h", e.learned_pid, lp);
        fails++;
      end
    endfunction
  endclass

  // Ways in which a generated PAT or PMT can be broken.
  typedef enum int {
    PF_NONE, PF_NO_START, PF_POINTER, PF_TABLE_ID, PF_SECLEN, PF_PROGINFO,
    PF_ENTRYINFO
  } psi_fault_t;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_BYTES = 60;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_ts_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic        out_pay_start;
  logic        out_packet_last;
  logic [12:0] out_learned_pid;
  logic        cfg_wr_en;
  logic [0:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  ts_packet_pid_demux dut (.*);

  pid_demux_predictor demux_model = new();

  // Packet under construction, the bytes waiting to be sent, and the PIDs
  // and stream types that the generated tables currently announce.
  bit [7:0]  pk[188];
  bit [7:0]  stream[$];
  bit [12:0] g_pmt = 13'h100;
  bit [12:0] g_vid = 13'h1E1;
  bit [12:0] g_aud = 13'h1E2;
  bit [7:0]  g_vtype, g_atype;
  bit        calm;
  int        sent;
  int        stall_cycles;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // The result side stalls about 38 times in a hundred, never while calm.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 38);
  end

  // Observe both handshakes at the edge; the watchdog counts edges with no
  // request moving on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) demux_model.accept_byte(in_ts_byte);
      if (out_valid && out_ready)
        demux_model.check_result(out_kind, out_data_byte, out_pay_start,
                                 out_packet_last, out_learned_pid);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Both type registers are written on consecutive edges, with the write
  // enable held high across them.
  task automatic set_types(bit [7:0] vt, bit [7:0] at);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_VIDEO_TYPE;
    cfg_wdata <= vt;
    @(posedge clk);
    cfg_index <= REG_AUDIO_TYPE;
    cfg_wdata <= at;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    demux_model.set_reg(REG_VIDEO_TYPE, vt);
    demux_model.set_reg(REG_AUDIO_TYPE, at);
    g_vtype = vt;
    g_atype = at;
  endtask

  // Sends every queued byte, holding each request until it is taken.
  task automatic flush_stream();
    foreach (stream[i]) begin
      while (!calm && $urandom_range(99) < 38) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_ts_byte <= stream[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
    sent += stream.size();
    stream.delete();
  endtask

  // Waits until every owed result is out and the block has settled.
  task automatic drain();
    while (demux_model.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic void put(int at, bit [7:0] v);
    if (at < 188) pk[at] = v;
  endfunction

  function automatic void commit(int n);
    for (int i = 0; i < n; i++) stream.push_back(pk[i]);
  endfunction

  // Random header, random body; returns where the payload begins.
  function automatic int new_packet(bit [12:0] pid, bit start, bit [1:0] ctl,
                                    bit [7:0] alen);
    foreach (pk[i]) pk[i] = 8'($urandom);
    pk[0] = SYNC_BYTE;
    pk[1] = {pk[1][7], start, pk[1][5], pid[12:8]};
    pk[2] = pid[7:0];
    pk[3] = {pk[3][7:6], ctl, pk[3][3:0]};
    if (ctl == 2'd3) begin
      pk[4] = alen;
      return 5 + alen;
    end
    return 4;
  endfunction

  task automatic es_packet(bit [12:0] pid, bit start, bit [1:0] ctl, bit [7:0] alen);
    void'(new_packet(pid, start, ctl, alen));
    commit(188);
  endtask

  // Elementary stream packet with mostly sane adaptation, rarely a broken
  // or payload-free one.
  task automatic es_random(bit [12:0] pid);
    int r;
    r = $urandom_range(99);
    if (r < 4) es_packet(pid, 1'($urandom), 2'd0, 8'd0);
    else if (r < 8) es_packet(pid, 1'($urandom), 2'd2, 8'($urandom));
    else if (r < 14) es_packet(pid, 1'($urandom), 2'd3, 8'($urandom_range(178, 255)));
    else if (r < 35) es_packet(pid, 1'($urandom), 2'd3, 8'($urandom_range(0, 20)));
    else es_packet(pid, 1'($urandom), 2'd1, 8'd0);
  endtask

  task automatic psi_packet(bit is_pmt, psi_fault_t fault);
    int st, ptr, base, pos, pil, eil, n, r, last_pos;
    bit [11:0] seclen;
    bit [7:0]  ty;
    bit [12:0] ep;
    if (!is_pmt && fault == PF_NONE && $urandom_range(3) == 0)
      g_pmt = 13'($urandom_range(16, 8190));
    if (is_pmt && $urandom_range(6) == 0) g_vid = 13'($urandom_range(16, 8190));
    if (is_pmt && $urandom_range(6) == 0) g_aud = 13'($urandom_range(16, 8190));
    st = new_packet(is_pmt ? g_pmt : 13'd0, fault != PF_NO_START,
                    $urandom_range(1) ? 2'd3 : 2'd1, 8'($urandom_range(0, 8)));
    ptr = (fault == PF_POINTER) ? 200 : $urandom_range(0, 2);
    base = st + 1 + ptr;
    put(st, 8'(ptr));
    put(base, fault == PF_TABLE_ID ? 8'h07 : (is_pmt ? 8'h02 : 8'h00));
    if (!is_pmt) begin
      seclen = 12'd13;
      put(base + 10, {3'b111, g_pmt[12:8]});
      put(base + 11, g_pmt[7:0]);
    end else begin
      pil = $urandom_range(0, 4);
      n = $urandom_range(1, 3);
      pos = base + 12 + pil;
      last_pos = pos + 3;
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(3);
        ty = (r == 0) ? g_vtype : (r == 1) ? g_atype : 8'($urandom);
        ep = (r == 0) ? g_vid : (r == 1) ? g_aud : 13'($urandom);
        eil = $urandom_range(0, 4);
        put(pos, ty);
        put(pos + 1, {3'b111, ep[12:8]});
        put(pos + 2, ep[7:0]);
        put(pos + 3, 8'hF0);
        put(pos + 4, 8'(eil));
        last_pos = pos + 3;
        pos += 5 + eil;
      end
      seclen = 12'(pos + 4 - base - 3);
      put(base + 10, 8'hF0);
      put(base + 11, 8'(pil));
      if (fault == PF_PROGINFO) begin
        put(base + 10, 8'hFF);
        put(base + 11, 8'hFF);
      end
      if (fault == PF_ENTRYINFO) begin
        put(last_pos, 8'hFF);
        put(last_pos + 1, 8'hFF);
      end
    end
    if (fault == PF_SECLEN) seclen = is_pmt ? 12'd5 : 12'd3;
    put(base + 1, {4'hB, seclen[11:8]});
    put(base + 2, seclen[7:0]);
    commit(188);
  endtask

  function automatic psi_fault_t pick_fault();
    if ($urandom_range(99) < 80) return PF_NONE;
    return psi_fault_t'($urandom_range(1, 6));
  endfunction

  // Mostly table and stream packets with random content; the rest is
  // unknown PIDs, stray bytes and packets cut short.
  task automatic random_phase();
    int start_count, r, n;
    start_count = sent;
    while (sent - start_count < PHASE_BYTES) begin
      r = $urandom_range(99);
      if (r < 8) psi_packet(1'b0, pick_fault());
      else if (r < 18) psi_packet(1'b1, pick_fault());
      else if (r < 60) es_random($urandom_range(1) ? g_vid : g_aud);
      else if (r < 75) es_random(13'($urandom));
      else if (r < 87) begin
        n = $urandom_range(1, 5);
        repeat (n) stream.push_back(8'($urandom));
      end else begin
        void'(new_packet($urandom_range(1) ? g_vid : 13'd0, 1'($urandom), 2'd1, 8'd0));
        commit($urandom_range(1, 187));
      end
      flush_stream();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_ts_byte = 8'd0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_VIDEO_TYPE;
    cfg_wdata = 8'd0;
    calm = 1'b0;
    sent = 0;
    stall_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_types(8'd27, 8'd15);

    // Directed: stray bytes around the sync value, then the table sequence,
    // a second PAT that may announce a new PMT PID, and the first payload packets.
    stream.push_back(8'h00);
    stream.push_back(8'hFF);
    stream.push_back(8'h46);
    stream.push_back(8'h48);
    stream.push_back(8'hC7);
    psi_packet(1'b0, PF_NONE);
    psi_packet(1'b0, PF_NONE);
    psi_packet(1'b1, PF_NONE);
    es_packet(g_vid, 1'b1, 2'd1, 8'd0);
    es_packet(g_aud, 1'b1, 2'd3, 8'd5);
    flush_stream();
    drain();

    // Random phases at several register settings, the extremes and equal
    // types among them; one phase runs with no idling on either side.
    random_phase();
    drain();
    set_types(8'd0, 8'd255);
    random_phase();
    drain();
    set_types(8'd255, 8'd0);
    calm = 1'b1;
    random_phase();
    drain();
    calm = 1'b0;
    g_vtype = 8'($urandom);
    set_types(g_vtype, g_vtype);
    random_phase();
    drain();
    set_types(8'($urandom), 8'($urandom));
    random_phase();
    drain();

    if (demux_model.fails == 0 && demux_model.expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/tpd_pkg.sv
rtl/core/tpd_parser.sv
rtl/core/tpd_queue.sv
rtl/core/ts_packet_pid_demux.sv
verif/ts_packet_pid_demux_tb.sv
